FILE: sv/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types, constants and helpers of the byte-run block encoder: segment
// modes, the command that the front hands to the back, and header forming.
// ----------------------------------------------------------------------------
package brle_pkg;

	// default block length limit in bytes
	localparam int BLOCK_MAX_DEF = 128;

	// encoded bytes packed into one output word
	localparam int OUT_BYTES = 4;
	localparam int FILL_W    = $clog2(OUT_BYTES);

	// segment lengths travel as full header-sized bytes (at most 128)
	localparam int SEG_LEN_W = 8;

	// depth of the command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

	// header flag for a run segment
	localparam logic [7:0] RUN_FLAG = 8'h80;

	// open segment in the front
	typedef enum logic [1:0] {
		SEG_NONE,
		SEG_SINGLE,
		SEG_RUN,
		SEG_LIT
	} seg_mode_t;

	// phase of the back end while it writes one command
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_P0H,
		BK_P0V,
		BK_LHDR,
		BK_LDAT,
		BK_P1H,
		BK_P1V
	} back_state_t;

	// one command: optional pair, optional literal, optional pair, in that order
	typedef struct packed {
		logic                 pair0_en;
		logic [7:0]           pair0_hdr;
		logic [7:0]           pair0_val;
		logic                 lit_en;
		logic                 lit_bank;
		logic [SEG_LEN_W-1:0] lit_len;
		logic                 pair1_en;
		logic [7:0]           pair1_hdr;
		logic [7:0]           pair1_val;
		logic                 last;
	} cmd_t;

	// segment header: flag bit and length minus one in the low seven bits
	function automatic logic [7:0] hdr_byte(input logic is_run,
			input logic [SEG_LEN_W-1:0] len);
		logic [SEG_LEN_W-1:0] len_m1;
		len_m1 = len - SEG_LEN_W'(1);
		return (is_run ? RUN_FLAG : 8'h00) | {1'b0, len_m1[6:0]};
	endfunction

endpackage

FILE: sv/byte_rle_block_encoder_core.sv
// ----------------------------------------------------------------------------
// byte_rle_block_encoder_core
// Byte-run block encoder: raw bytes in, run and literal segments out, packed
// four encoded bytes to a word.
// ----------------------------------------------------------------------------
// Usage: one raw byte is taken per cycle while full is low. A block closes on
// block_end or after BLOCK_MAX bytes, and its last word carries block_done.
// The front classifies bytes with one byte of lookahead and takes one byte a
// cycle; the back writes one encoded byte a cycle while its output register
// can take a word, so the sustained rate is set by the back. Literal bytes
// sit in a two-bank store; full rises while the two-entry command queue is
// full or the bank the front must write next is still being read out by the
// back. Words leave through a single output register that the next word may
// replace in the cycle it is popped.
// ----------------------------------------------------------------------------
module byte_rle_block_encoder_core #(
	parameter int BLOCK_MAX = brle_pkg::BLOCK_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        block_end,
	input  logic        push,
	output logic        full,
	output logic [31:0] out_word,
	output logic [2:0]  byte_count,
	output logic        block_done,
	output logic        empty,
	input  logic        pop
);
	import brle_pkg::*;

	localparam int IDX_W = $clog2(BLOCK_MAX);

	logic             cq_push, cq_full, cq_pop, cq_empty;
	cmd_t             cq_cmd, cq_head;
	logic             st_we;
	logic [IDX_W:0]   st_waddr;
	logic [7:0]       st_wdata;
	logic             rel_en, rel_bank;

	// classifier and literal writer
	brle_front #(
		.BLOCK_MAX (BLOCK_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.block_end (block_end),
		.push      (push),
		.full      (full),
		.cq_push   (cq_push),
		.cq_cmd    (cq_cmd),
		.cq_full   (cq_full),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_wdata  (st_wdata),
		.rel_en    (rel_en),
		.rel_bank  (rel_bank)
	);

	// command queue
	brle_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cq_push  (cq_push),
		.cq_cmd   (cq_cmd),
		.cq_full  (cq_full),
		.cq_pop   (cq_pop),
		.cq_empty (cq_empty),
		.cq_head  (cq_head)
	);

	// byte writer and word packer
	brle_back #(
		.BLOCK_MAX (BLOCK_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cq_empty   (cq_empty),
		.cq_head    (cq_head),
		.cq_pop     (cq_pop),
		.st_we      (st_we),
		.st_waddr   (st_waddr),
		.st_wdata   (st_wdata),
		.rel_en     (rel_en),
		.rel_bank   (rel_bank),
		.out_word   (out_word),
		.byte_count (byte_count),
		.block_done (block_done),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

FILE: sv/brle_front.sv
// ----------------------------------------------------------------------------
// brle_front
// Accepts raw bytes, tracks the open segment with one byte of lookahead,
// writes literal bytes into the ping-pong literal store and issues commands.
// ----------------------------------------------------------------------------
module brle_front #(
	parameter int BLOCK_MAX = brle_pkg::BLOCK_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [7:0]                     data_byte,
	input  logic                           block_end,
	input  logic                           push,
	output logic                           full,
	output logic                           cq_push,
	output brle_pkg::cmd_t                 cq_cmd,
	input  logic                           cq_full,
	output logic                           st_we,
	output logic [$clog2(BLOCK_MAX):0]     st_waddr,
	output logic [7:0]                     st_wdata,
	input  logic                           rel_en,
	input  logic                           rel_bank
);
	import brle_pkg::*;

	localparam int IDX_W = $clog2(BLOCK_MAX);
	localparam int LEN_W = $clog2(BLOCK_MAX + 1);

	seg_mode_t         mode_q, mode_mid, mode_d;
	logic [7:0]        held_q, held_mid;
	logic [LEN_W-1:0]  seg_len_q, len_mid;
	logic [IDX_W-1:0]  blk_cnt_q;
	logic              cur_bank_q;
	logic [1:0]        busy_q;
	logic              accept, close, eq, flip;
	logic [IDX_W-1:0]  wr_idx;

	// input handshake: stall on a full queue or a bank still being drained
	assign full   = cq_full || busy_q[cur_bank_q];
	assign accept = push && !full;
	assign eq     = (data_byte == held_q);
	assign close  = block_end || (blk_cnt_q == IDX_W'(BLOCK_MAX - 1));

	// segment mode after this byte, then after a possible block close
	always_comb begin
		mode_mid = mode_q;
		unique case (mode_q)
			SEG_NONE:   mode_mid = SEG_SINGLE;
			SEG_SINGLE: mode_mid = eq ? SEG_RUN : SEG_LIT;
			SEG_RUN:    mode_mid = eq ? SEG_RUN : SEG_SINGLE;
			SEG_LIT:    mode_mid = eq ? SEG_RUN : SEG_LIT;
			default:    mode_mid = SEG_NONE;
		endcase
		mode_d = mode_q;
		if (accept) begin
			mode_d = close ? SEG_NONE : mode_mid;
		end
	end

	// datapath, store writes and command forming
	always_comb begin
		held_mid = held_q;
		len_mid  = seg_len_q;
		st_we    = 1'b0;
		wr_idx   = '0;
		flip     = 1'b0;
		cq_cmd   = '0;
		unique case (mode_q)
			SEG_NONE: begin
				held_mid = data_byte;
				len_mid  = LEN_W'(1);
				st_we    = 1'b1;
			end
			SEG_SINGLE: begin
				len_mid = LEN_W'(2);
				if (!eq) begin
					held_mid = data_byte;
					st_we    = 1'b1;
					wr_idx   = IDX_W'(1);
				end
			end
			SEG_RUN: begin
				if (eq) begin
					len_mid = seg_len_q + LEN_W'(1);
				end else begin
					cq_cmd.pair0_en  = 1'b1;
					cq_cmd.pair0_hdr = hdr_byte(1'b1, SEG_LEN_W'(seg_len_q));
					cq_cmd.pair0_val = held_q;
					held_mid = data_byte;
					len_mid  = LEN_W'(1);
					st_we    = 1'b1;
				end
			end
			SEG_LIT: begin
				if (eq) begin
					// literal ends before the equal pair, the pair opens a run
					cq_cmd.lit_en   = 1'b1;
					cq_cmd.lit_bank = cur_bank_q;
					cq_cmd.lit_len  = SEG_LEN_W'(seg_len_q - LEN_W'(1));
					flip    = 1'b1;
					len_mid = LEN_W'(2);
				end else begin
					held_mid = data_byte;
					len_mid  = seg_len_q + LEN_W'(1);
					st_we    = 1'b1;
					wr_idx   = seg_len_q[IDX_W-1:0];
				end
			end
			default: begin
				held_mid = held_q;
			end
		endcase
		// block close writes out whatever segment is open
		if (close) begin
			cq_cmd.last = 1'b1;
			if (mode_mid == SEG_SINGLE) begin
				cq_cmd.pair1_en  = 1'b1;
				cq_cmd.pair1_hdr = 8'h00;
				cq_cmd.pair1_val = held_mid;
			end else if (mode_mid == SEG_RUN) begin
				cq_cmd.pair1_en  = 1'b1;
				cq_cmd.pair1_hdr = hdr_byte(1'b1, SEG_LEN_W'(len_mid));
				cq_cmd.pair1_val = held_mid;
			end else if (mode_mid == SEG_LIT) begin
				cq_cmd.lit_en   = 1'b1;
				cq_cmd.lit_bank = cur_bank_q;
				cq_cmd.lit_len  = SEG_LEN_W'(len_mid);
				flip = 1'b1;
			end
		end
		st_we = st_we && accept;
	end

	assign st_waddr = {cur_bank_q, wr_idx};
	assign st_wdata = data_byte;
	assign cq_push  = accept &&
		(cq_cmd.pair0_en || cq_cmd.lit_en || cq_cmd.pair1_en);

	// segment state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= SEG_NONE;
			held_q     <= '0;
			seg_len_q  <= '0;
			blk_cnt_q  <= '0;
			cur_bank_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			if (accept) begin
				if (close) begin
					held_q    <= '0;
					seg_len_q <= '0;
					blk_cnt_q <= '0;
				end else begin
					held_q    <= held_mid;
					seg_len_q <= len_mid;
					blk_cnt_q <= blk_cnt_q + IDX_W'(1);
				end
				if (flip) begin
					cur_bank_q <= !cur_bank_q;
				end
			end
		end
	end

	// bank ownership: set when a literal is issued, cleared once drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (cq_push && cq_cmd.lit_en && (cur_bank_q == 1'(b))) begin
					busy_q[b] <= 1'b1;
				end else if (rel_en && (rel_bank == 1'(b))) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cq_push |-> !cq_full)
		else $error("command pushed into a full queue");

	a_lit_free_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(st_we || (cq_push && cq_cmd.lit_en)) |-> !busy_q[cur_bank_q])
		else $error("literal store bank used while still being drained");

	a_close_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && close) |-> (cq_push && cq_cmd.last))
		else $error("block close without a closing command");

	a_none_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == SEG_NONE) |-> (seg_len_q == '0))
		else $error("segment length set with no open segment");

endmodule

FILE: sv/brle_cmdq.sv
// ----------------------------------------------------------------------------
// brle_cmdq
// Short first-in first-out queue of segment commands between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module brle_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cq_push,
	input  brle_pkg::cmd_t cq_cmd,
	output logic           cq_full,
	input  logic           cq_pop,
	output logic           cq_empty,
	output brle_pkg::cmd_t cq_head
);
	import brle_pkg::*;

	cmd_t                  ent_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_PTR_W:0]   cnt_q;

	// occupancy flags and head entry
	assign cq_full  = (cnt_q == (CMDQ_PTR_W + 1)'(CMDQ_DEPTH));
	assign cq_empty = (cnt_q == '0);
	assign cq_head  = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (cq_push) begin
			ent_q[wr_ptr_q] <= cq_cmd;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cq_push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (cq_pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			end
			if (cq_push && !cq_pop) begin
				cnt_q <= cnt_q + (CMDQ_PTR_W + 1)'(1);
			end else if (cq_pop && !cq_push) begin
				cnt_q <= cnt_q - (CMDQ_PTR_W + 1)'(1);
			end
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty)
		else $error("command queue popped while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cq_push |-> (!cq_full || cq_pop))
		else $error("command queue pushed while full");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cq_push && !cq_pop) |=> (cnt_q == $past(cnt_q) + (CMDQ_PTR_W + 1)'(1)))
		else $error("command queue count did not follow a push");

endmodule

FILE: sv/brle_back.sv
// ----------------------------------------------------------------------------
// brle_back
// Carries out segment commands one encoded byte per cycle unless the output
// stalls: run pairs, literal header and store bytes, packed into words.
// ----------------------------------------------------------------------------
module brle_back #(
	parameter int BLOCK_MAX = brle_pkg::BLOCK_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cq_empty,
	input  brle_pkg::cmd_t             cq_head,
	output logic                       cq_pop,
	input  logic                       st_we,
	input  logic [$clog2(BLOCK_MAX):0] st_waddr,
	input  logic [7:0]                 st_wdata,
	output logic                       rel_en,
	output logic                       rel_bank,
	output logic [31:0]                out_word,
	output logic [2:0]                 byte_count,
	output logic                       block_done,
	output logic                       empty,
	input  logic                       pop
);
	import brle_pkg::*;

	localparam int IDX_W = $clog2(BLOCK_MAX);

	logic [7:0]        store_mem [2**(IDX_W + 1)];
	logic [7:0]        rd_q;
	logic [IDX_W-1:0]  rd_idx;

	back_state_t       state_q, state_d;
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       pack_q;
	logic [FILL_W-1:0] fill_q;
	logic [31:0]       out_word_q;
	logic [2:0]        out_cnt_q;
	logic              out_done_q, out_valid_q;

	logic              active, cmd_end, blk_last, idx_end;
	logic              word_out, out_free, adv, out_load;
	logic [7:0]        byte_d;
	logic [31:0]       merged;

	// first phase of a command
	function automatic back_state_t first_phase(input cmd_t c);
		if (c.pair0_en) begin
			return BK_P0H;
		end else if (c.lit_en) begin
			return BK_LHDR;
		end
		return BK_P1H;
	endfunction

	assign idx_end  = ((SEG_LEN_W'(idx_q) + SEG_LEN_W'(1)) == cmd_q.lit_len);
	assign out_free = !out_valid_q || pop;

	// byte of this phase and end of command
	always_comb begin
		active  = 1'b1;
		cmd_end = 1'b0;
		byte_d  = 8'h00;
		unique case (state_q)
			BK_IDLE: active = 1'b0;
			BK_P0H:  byte_d = cmd_q.pair0_hdr;
			BK_P0V: begin
				byte_d  = cmd_q.pair0_val;
				cmd_end = !cmd_q.lit_en && !cmd_q.pair1_en;
			end
			BK_LHDR: byte_d = hdr_byte(1'b0, cmd_q.lit_len);
			BK_LDAT: begin
				byte_d  = rd_q;
				cmd_end = idx_end && !cmd_q.pair1_en;
			end
			BK_P1H:  byte_d = cmd_q.pair1_hdr;
			BK_P1V: begin
				byte_d  = cmd_q.pair1_val;
				cmd_end = 1'b1;
			end
			default: active = 1'b0;
		endcase
		blk_last = cmd_end && cmd_q.last;
		word_out = (fill_q == FILL_W'(OUT_BYTES - 1)) || blk_last;
		adv      = active && (!word_out || out_free);
		out_load = adv && word_out;
		cq_pop   = !cq_empty && (!active || (adv && cmd_end));
		rel_en   = adv && (state_q == BK_LDAT) && idx_end;
		rel_bank = cmd_q.lit_bank;
	end

	// phase sequencing
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!cq_empty) begin
					state_d = first_phase(cq_head);
				end
			end
			default: begin
				if (adv && cmd_end) begin
					state_d = cq_empty ? BK_IDLE : first_phase(cq_head);
				end else if (adv) begin
					unique case (state_q)
						BK_P0H:  state_d = BK_P0V;
						BK_P0V:  state_d = cmd_q.lit_en ? BK_LHDR : BK_P1H;
						BK_LHDR: state_d = BK_LDAT;
						BK_LDAT: state_d = idx_end ? BK_P1H : BK_LDAT;
						BK_P1H:  state_d = BK_P1V;
						default: state_d = BK_IDLE;
					endcase
				end
			end
		endcase
	end

	// literal store: written by the front, read one byte ahead here
	always_comb begin
		rd_idx = '0;
		if (state_q == BK_LDAT) begin
			rd_idx = adv ? (idx_q + IDX_W'(1)) : idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		rd_q <= store_mem[{cmd_q.lit_bank, rd_idx}];
	end

	// command register and literal index
	always_ff @(posedge clk) begin
		if (cq_pop) begin
			cmd_q <= cq_head;
		end
		if (adv && (state_q == BK_LHDR)) begin
			idx_q <= '0;
		end else if (adv && (state_q == BK_LDAT)) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	assign merged = pack_q | (32'(byte_d) << {fill_q, 3'b000});

	// phase register, word packer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pack_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_cnt_q   <= '0;
			out_done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_word_q  <= merged;
				out_cnt_q   <= 3'(fill_q) + 3'd1;
				out_done_q  <= blk_last;
				out_valid_q <= 1'b1;
				pack_q      <= '0;
				fill_q      <= '0;
			end else begin
				if (pop) begin
					out_valid_q <= 1'b0;
				end
				if (adv) begin
					pack_q <= merged;
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	assign out_word   = out_word_q;
	assign byte_count = out_cnt_q;
	assign block_done = out_done_q;
	assign empty      = !out_valid_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_cnt_q != 3'd0) && (out_cnt_q <= 3'(OUT_BYTES))))
		else $error("output word byte count out of range");

	a_done_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && blk_last) |=> (fill_q == '0))
		else $error("packer not empty after the last word of a block");

	a_lit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == BK_LHDR) || (state_q == BK_LDAT)) |-> cmd_q.lit_en)
		else $error("literal phase for a command without a literal");

	a_short_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_cnt_q != 3'(OUT_BYTES))) |-> out_done_q)
		else $error("partial word without block end");

endmodule

FILE: tb/brle_score_pkg.sv
// ----------------------------------------------------------------------------
// brle_score_pkg
// Scoreboard for the byte-run block encoder: a bit-exact predictor that turns
// each accepted raw byte into the encoded words it releases, and a checker
// that compares every popped word against the oldest predicted one.
// ----------------------------------------------------------------------------
package brle_score_pkg;
	import brle_pkg::*;

	// one encoded output word as the block presents it
	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  count;
		logic        done;
	} enc_word_t;

	class rle_scoreboard;
		// encoder state mirrored from the block's behavior
		logic [7:0] lit_bytes [BLOCK_MAX_DEF];
		logic [7:0] held;
		int         seg_len;
		seg_mode_t  mode;
		int         blk_bytes;
		logic [31:0] pack;
		int         pack_fill;

		// words released by the byte being processed, then all words still owed
		enc_word_t  step_words [$];
		enc_word_t  owed_words [$];
		int         mismatches;

		function new();
			foreach (lit_bytes[i]) lit_bytes[i] = 8'h00;
			held       = 8'h00;
			seg_len    = 0;
			mode       = SEG_NONE;
			blk_bytes  = 0;
			pack       = 32'h0;
			pack_fill  = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		// pack one encoded byte, releasing a full word when the lanes are used up
		function void put_byte(logic [7:0] b);
			enc_word_t w;
			pack = pack | (32'(b) << (8 * pack_fill));
			pack_fill++;
			if (pack_fill >= OUT_BYTES) begin
				w.data  = pack;
				w.count = 3'(pack_fill);
				w.done  = 1'b0;
				step_words.push_back(w);
				pack      = 32'h0;
				pack_fill = 0;
			end
		endfunction

		function void put_run(logic [7:0] v, int len);
			put_byte(RUN_FLAG | {1'b0, 7'(len - 1)});
			put_byte(v);
		endfunction

		function void put_literal(int len);
			put_byte({1'b0, 7'(len - 1)});
			for (int i = 0; i < len && i < BLOCK_MAX_DEF; i++)
				put_byte(lit_bytes[i]);
		endfunction

		// predict the words released by one accepted raw byte
		function void take_byte(logic [7:0] x, logic last);
			enc_word_t w;
			step_words.delete();

			case (mode)
				SEG_SINGLE: begin
					if (x == held) begin
						mode    = SEG_RUN;
						seg_len = 2;
					end else begin
						lit_bytes[0] = held;
						lit_bytes[1] = x;
						held    = x;
						seg_len = 2;
						mode    = SEG_LIT;
					end
				end
				SEG_RUN: begin
					if (x == held && seg_len < BLOCK_MAX_DEF) begin
						seg_len++;
					end else begin
						put_run(held, seg_len);
						held    = x;
						seg_len = 1;
						mode    = SEG_SINGLE;
					end
				end
				SEG_LIT: begin
					if (x == held) begin
						// the equal pair leaves the literal and opens a run
						put_literal(seg_len - 1);
						seg_len = 2;
						mode    = SEG_RUN;
					end else if (seg_len < BLOCK_MAX_DEF) begin
						lit_bytes[seg_len] = x;
						seg_len++;
						held = x;
					end else begin
						put_literal(seg_len);
						held    = x;
						seg_len = 1;
						mode    = SEG_SINGLE;
					end
				end
				default: begin
					held    = x;
					seg_len = 1;
					mode    = SEG_SINGLE;
				end
			endcase

			// block close: flush the open segment and the partial word
			blk_bytes++;
			if (last || blk_bytes >= BLOCK_MAX_DEF) begin
				case (mode)
					SEG_SINGLE: begin
						put_byte(8'h00);
						put_byte(held);
					end
					SEG_RUN: put_run(held, seg_len);
					SEG_LIT: put_literal(seg_len);
					default: ;
				endcase
				if (pack_fill > 0) begin
					w.data  = pack;
					w.count = 3'(pack_fill);
					w.done  = 1'b1;
					step_words.push_back(w);
					pack      = 32'h0;
					pack_fill = 0;
				end else if (step_words.size() > 0) begin
					step_words[step_words.size() - 1].done = 1'b1;
				end
				held      = 8'h00;
				seg_len   = 0;
				mode      = SEG_NONE;
				blk_bytes = 0;
			end

			foreach (step_words[i]) owed_words.push_back(step_words[i]);
		endfunction

		// compare one popped word with the oldest owed word
		function void check_word(logic [31:0] data, logic [2:0] count, logic done);
			enc_word_t want;
			if (owed_words.size() == 0) begin
				$error("unexpected word: out_word=%h byte_count=%0d block_done=%b",
					data, count, done);
				mismatches++;
				return;
			end
			want = owed_words.pop_front();
			if (data !== want.data) begin
				$error("out_word: expected %h, actual %h", want.data, data);
				mismatches++;
			end
			if (count !== want.count) begin
				$error("byte_count: expected %0d, actual %0d", want.count, count);
				mismatches++;
			end
			if (done !== want.done) begin
				$error("block_done: expected %b, actual %b", want.done, done);
				mismatches++;
			end
		endfunction
	endclass

endpackage

FILE: tb/byte_rle_block_encoder_core_test.sv
// ----------------------------------------------------------------------------
// byte_rle_block_encoder_core_test
// Drives raw bytes into the encoder and checks every encoded word: a directed
// pass over runs, literals and block closes, full 128-byte blocks under a long
// output stall, then random blocks with random idling on both sides.
// ----------------------------------------------------------------------------
module byte_rle_block_encoder_core_test;
	import brle_pkg::*;
	import brle_score_pkg::*;

	localparam int TOTAL_BYTES  = 500;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE       = 64;
	localparam int STALL_LEN    = 300;

	logic        clk;
	logic        arst_n;
	logic [7:0]  data_byte;
	logic        block_end;
	logic        push;
	logic        full;
	logic [31:0] out_word;
	logic [2:0]  byte_count;
	logic        block_done;
	logic        empty;
	logic        pop;

	rle_scoreboard sb;
	int          cycles;
	int          hold_req;
	bit          send_quiet;
	bit          recv_quiet;
	int          bytes_sent;

	byte_rle_block_encoder_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_byte  (data_byte),
		.block_end  (block_end),
		.push       (push),
		.full       (full),
		.out_word   (out_word),
		.byte_count (byte_count),
		.block_done (block_done),
		.empty      (empty),
		.pop        (pop)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// offer one raw byte after a random gap and wait until it is taken
	task automatic send_byte(logic [7:0] d, logic last);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_byte <= d;
		block_end <= last;
		push      <= 1'b1;
		do @(posedge clk); while (full);
		sb.take_byte(d, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	// stop offering and wait for every owed word to come out
	task automatic wait_drained();
		push <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// block of bytes with random repeats so that runs and literals both appear
	task automatic send_block(int len, bit mark_end);
		logic [7:0] prev;
		logic [7:0] d;
		logic [7:0] base;
		bit         narrow;
		int         rep_pct;
		narrow  = 1'($urandom_range(0, 1));
		base    = 8'($urandom_range(0, 255));
		rep_pct = $urandom_range(0, 80);
		prev    = 8'h00;
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 99) < rep_pct)
				d = prev;
			else if (narrow)
				d = base + 8'($urandom_range(0, 2));
			else
				d = 8'($urandom_range(0, 255));
			send_byte(d, mark_end && (i == len - 1));
			prev = d;
		end
	endtask

	// output side: random pops, plus a long stall on request
	initial begin : drain_proc
		int gap;
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				pop <= 1'b0;
				while (n > 0) begin
					@(negedge clk);
					n--;
				end
			end
			gap = recv_quiet ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_word(out_word, byte_count, block_done);
			if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
			@(negedge clk);
		end
	end

	// input side: reset, directed blocks, long blocks, random blocks, end
	initial begin : stim_proc
		int r;
		int len;
		logic [7:0] d;
		sb         = new();
		hold_req   = 0;
		send_quiet = 1'b0;
		recv_quiet = 1'b0;
		bytes_sent = 0;
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		data_byte  = 8'h00;
		block_end  = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-byte blocks at both data extremes
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b1);
		// pure run
		send_byte(8'haa, 1'b0);
		send_byte(8'haa, 1'b0);
		send_byte(8'haa, 1'b1);
		// literal that takes the final byte of the block
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h03, 1'b1);
		// literal, run, then a lone byte at the close
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h05, 1'b0);
		send_byte(8'h07, 1'b1);
		// pair run followed by a lone byte
		send_byte(8'h09, 1'b0);
		send_byte(8'h09, 1'b0);
		send_byte(8'h08, 1'b1);
		// literal cut short by an equal pair at the close
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h02, 1'b1);
		// sender pause until all owed words are out
		wait_drained();

		// full-length literal while the output stalls, so the input backs up
		send_quiet = 1'b1;
		hold_req   = STALL_LEN;
		d = 8'($urandom_range(0, 255));
		for (int i = 0; i < BLOCK_MAX_DEF; i++) begin
			d = d + 8'($urandom_range(1, 255));
			send_byte(d, i == BLOCK_MAX_DEF - 1);
		end
		// short literal in the other bank, both banks now held by the back
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b1);
		// full-length run closed by the length limit alone, offered while full
		for (int i = 0; i < BLOCK_MAX_DEF; i++) send_byte(8'h5a, 1'b0);
		send_quiet = 1'b0;
		// mixed block closed by the length limit
		send_block(BLOCK_MAX_DEF, 1'b0);

		// random blocks, mostly short
		while (bytes_sent < TOTAL_BYTES) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 7) == 0) send_quiet = !send_quiet;
			if (r < 4) begin
				send_block(BLOCK_MAX_DEF, 1'($urandom_range(0, 1)));
			end else if (r < 25) begin
				send_block($urandom_range(9, 40), 1'b1);
			end else if (r < 88) begin
				send_block($urandom_range(1, 8), 1'b1);
			end else begin
				// noise: arbitrary bytes with arbitrary end marks
				len = $urandom_range(1, 20);
				for (int i = 0; i < len; i++)
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
			end
		end
		// close whatever block the noise left open
		send_byte(8'($urandom_range(0, 255)), 1'b1);

		wait_drained();
		repeat (SETTLE) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
